// ===== src/sfla_pkg.sv =====
// Package: shared types, geometry constants and the size-class function for the allocator.
package sfla_pkg;

  localparam int HEADER_BYTES   = 16;
  localparam int MEM_BYTES      = 65536;
  localparam int MIN_CLASS_LOG2 = 4;
  localparam int MAX_CLASS_LOG2 = 12;

  localparam int TOTAL_UNITS = MEM_BYTES / HEADER_BYTES;
  localparam int NUM_CLASSES = MAX_CLASS_LOG2 - MIN_CLASS_LOG2 + 1;
  localparam int UNIT_W      = $clog2(TOTAL_UNITS);
  localparam int BUMP_W      = UNIT_W + 1;
  localparam int CLASS_W     = $clog2(NUM_CLASSES);
  localparam int SIZE_W      = 13;
  localparam int ADDR_W      = 16;
  localparam int OFFS_W      = $clog2(HEADER_BYTES);

  localparam logic [BUMP_W-1:0] TOTAL_UNITS_B = BUMP_W'(TOTAL_UNITS);
  localparam logic [SIZE_W-1:0] MAX_REQ_BYTES = SIZE_W'(1 << MAX_CLASS_LOG2);

  typedef logic [UNIT_W-1:0]  unit_t;
  typedef logic [CLASS_W-1:0] class_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } sfla_state_t;

  // Heap memory requests from the controller.
  typedef struct packed {
    logic   rd_en;
    unit_t  rd_addr;
    logic   cls_we;
    unit_t  cls_waddr;
    class_t cls_wdata;
    logic   lnk_we;
    unit_t  lnk_waddr;
    unit_t  lnk_wdata;
  } mem_req_t;

  typedef struct packed {
    class_t cls;
    unit_t  lnk;
  } mem_rsp_t;

  // Class index for a request size: ceil(log2(size)) minus MIN_CLASS_LOG2, clamped to the minimum class.
  function automatic logic [CLASS_W:0] size_class(input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] v;
    logic [3:0]        lg;
    v  = size - SIZE_W'(1);
    lg = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (v[i]) lg = 4'(i + 1);
    end
    if (lg < 4'(MIN_CLASS_LOG2)) lg = 4'(MIN_CLASS_LOG2);
    return (CLASS_W + 1)'(lg - 4'(MIN_CLASS_LOG2));
  endfunction

  // Payload byte address of the block whose header sits at unit u.
  function automatic logic [ADDR_W-1:0] payload_addr(input unit_t u);
    unit_t nx;
    nx = u + UNIT_W'(1);
    return ADDR_W'({nx, {OFFS_W{1'b0}}});
  endfunction

endpackage

// ===== src/sfla_heap_mem.sv =====
// Heap header memories: class index and next link per unit, one shared read port.
module sfla_heap_mem (
  input  logic              clk,
  input  sfla_pkg::mem_req_t req,
  output sfla_pkg::mem_rsp_t rsp
);
  import sfla_pkg::*;

  class_t cls_mem [TOTAL_UNITS];
  unit_t  lnk_mem [TOTAL_UNITS];
  class_t cls_q_r;
  unit_t  lnk_q_r;

  always_ff @(posedge clk) begin
    if (req.cls_we) cls_mem[req.cls_waddr] <= req.cls_wdata;
    if (req.rd_en)  cls_q_r <= cls_mem[req.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (req.lnk_we) lnk_mem[req.lnk_waddr] <= req.lnk_wdata;
    if (req.rd_en)  lnk_q_r <= lnk_mem[req.rd_addr];
  end

  assign rsp.cls = cls_q_r;
  assign rsp.lnk = lnk_q_r;

endmodule

// ===== src/sfla_ctrl.sv =====
// Controller: request decode, class list registers, bump pointer and result register.
module sfla_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_mode,
  input  logic [sfla_pkg::SIZE_W-1:0]  in_request_bytes,
  input  logic [sfla_pkg::ADDR_W-1:0]  in_free_address,
  output logic                         out_valid,
  output logic [sfla_pkg::ADDR_W-1:0]  out_block_address,
  output logic                         out_granted,
  output sfla_pkg::mem_req_t           mem_req,
  input  sfla_pkg::mem_rsp_t           mem_rsp
);
  import sfla_pkg::*;

  sfla_state_t state_r, state_nxt;

  unit_t                 head_r [NUM_CLASSES];
  unit_t                 tail_r [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] nonempty_r;
  logic [BUMP_W-1:0]     bump_r;

  logic              mode_r;
  class_t            idx_r;
  logic              size_ok_r;
  logic              fvalid_r;
  unit_t             funit_r;
  logic [ADDR_W-1:0] faddr_r;

  logic              out_valid_r;
  logic [ADDR_W-1:0] out_addr_r, out_addr_nxt;
  logic              out_granted_r, out_granted_nxt;

  logic              acc;
  logic [CLASS_W:0]  idx_raw;
  class_t            idx_in;
  logic              size_ok_in;
  logic [UNIT_W-1:0] pay_in;
  unit_t             funit_in;
  logic              fvalid_in;

  logic              do_pop, do_carve, do_append, room;
  logic [BUMP_W-1:0] need;

  assign acc = start && (state_r == ST_IDLE);

  // Accept-side decode
  always_comb begin
    idx_raw    = size_class(in_request_bytes);
    size_ok_in = (in_request_bytes != '0) && (in_request_bytes <= MAX_REQ_BYTES);
    idx_in     = (size_ok_in && (idx_raw < (CLASS_W + 1)'(NUM_CLASSES))) ?
                 idx_raw[CLASS_W-1:0] : '0;
    pay_in     = in_free_address[ADDR_W-1:OFFS_W];
    funit_in   = pay_in - UNIT_W'(1);
    fvalid_in  = (pay_in != '0) && ({1'b0, funit_in} < bump_r);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Execute-side decisions
  always_comb begin
    do_pop    = !mode_r && size_ok_r && nonempty_r[idx_r];
    need      = BUMP_W'(1) + (BUMP_W'(1) << idx_r);
    room      = (bump_r < TOTAL_UNITS_B) && (need <= (TOTAL_UNITS_B - bump_r));
    do_carve  = !mode_r && size_ok_r && !do_pop && room;
    do_append = mode_r && fvalid_r && (mem_rsp.cls < CLASS_W'(NUM_CLASSES));
  end

  // Outputs of the state machine
  always_comb begin
    busy            = 1'b0;
    mem_req         = '0;
    out_addr_nxt    = '0;
    out_granted_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        mem_req.rd_en   = acc;
        mem_req.rd_addr = in_mode ? funit_in : head_r[idx_in];
      end
      ST_EXEC: begin
        busy              = 1'b1;
        mem_req.cls_we    = do_carve;
        mem_req.cls_waddr = bump_r[UNIT_W-1:0];
        mem_req.cls_wdata = idx_r;
        mem_req.lnk_we    = do_append && nonempty_r[mem_rsp.cls];
        mem_req.lnk_waddr = tail_r[mem_rsp.cls];
        mem_req.lnk_wdata = funit_r;
        out_granted_nxt   = mode_r || do_pop || do_carve;
        if (mode_r)        out_addr_nxt = faddr_r;
        else if (do_pop)   out_addr_nxt = payload_addr(head_r[idx_r]);
        else if (do_carve) out_addr_nxt = payload_addr(bump_r[UNIT_W-1:0]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      nonempty_r  <= '0;
      bump_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_EXEC);
      if (state_r == ST_EXEC) begin
        if (do_pop && (head_r[idx_r] == tail_r[idx_r])) nonempty_r[idx_r] <= 1'b0;
        if (do_append) nonempty_r[mem_rsp.cls] <= 1'b1;
        if (do_carve)  bump_r <= bump_r + need;
      end
    end
  end

  // List pointers and per-item registers, no reset needed
  always_ff @(posedge clk) begin
    if (acc) begin
      mode_r    <= in_mode;
      idx_r     <= idx_in;
      size_ok_r <= size_ok_in;
      fvalid_r  <= fvalid_in;
      funit_r   <= funit_in;
      faddr_r   <= in_free_address;
    end
    if (state_r == ST_EXEC) begin
      out_addr_r    <= out_addr_nxt;
      out_granted_r <= out_granted_nxt;
      if (do_pop && (head_r[idx_r] != tail_r[idx_r])) head_r[idx_r] <= mem_rsp.lnk;
      if (do_append) begin
        if (!nonempty_r[mem_rsp.cls]) head_r[mem_rsp.cls] <= funit_r;
        tail_r[mem_rsp.cls] <= funit_r;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_block_address = out_addr_r;
  assign out_granted       = out_granted_r;

endmodule

// ===== src/segregated_free_list_allocator_top.sv =====
// Top level of the segregated power-of-two free-list allocator.
// For each request, busy is high only in the cycle after start is taken, in
// which the header word read at accept is used and header updates are written;
// the result appears with out_valid for exactly one cycle right after that and
// must be captured then, since the receiver cannot stall. A new request may be
// issued in the same cycle as that result. The heap is 64 KiB in 16-byte units
// with size classes 16 B to 4 KiB; no clearing pass is needed after reset.
module segregated_free_list_allocator_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_mode,
  input  logic [sfla_pkg::SIZE_W-1:0]  in_request_bytes,
  input  logic [sfla_pkg::ADDR_W-1:0]  in_free_address,
  output logic                         out_valid,
  output logic [sfla_pkg::ADDR_W-1:0]  out_block_address,
  output logic                         out_granted
);
  import sfla_pkg::*;

  mem_req_t mem_req;
  mem_rsp_t mem_rsp;

  sfla_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_mode           (in_mode),
    .in_request_bytes  (in_request_bytes),
    .in_free_address   (in_free_address),
    .out_valid         (out_valid),
    .out_block_address (out_block_address),
    .out_granted       (out_granted),
    .mem_req           (mem_req),
    .mem_rsp           (mem_rsp)
  );

  sfla_heap_mem u_mem (
    .clk (clk),
    .req (mem_req),
    .rsp (mem_rsp)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  a_exec_one: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (!busy && out_valid))
    else $error("execute cycle did not end with a result");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a preceding execute cycle");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_granted) |-> (out_block_address == '0))
    else $error("failed allocation carries a nonzero address");

endmodule
